>>> design/wmh_pkg.sv
// Package for the window minimizer hash block: payload structs, stage record,
// register indexes and the masked integer hash. No dependencies.
`timescale 1ns / 1ps

package wmh_pkg;

  localparam int KMER_MAX   = 15;
  localparam int WINDOW_MAX = 255;

  localparam int KEY_W   = 2 * KMER_MAX;
  localparam int KLEN_W  = 4;
  localparam int WLEN_W  = 8;
  localparam int COUNT_W = 8;
  localparam int CFG_W   = 8;

  // Register indexes of the configuration port.
  localparam logic REG_KMER_LEN   = 1'b0;
  localparam logic REG_WINDOW_LEN = 1'b1;

  // Shift amounts of the hash rounds.
  localparam int SH_A = 21;
  localparam int SH_B = 24;
  localparam int SH_C = 3;
  localparam int SH_D = 8;
  localparam int SH_E = 14;
  localparam int SH_F = 2;
  localparam int SH_G = 4;
  localparam int SH_H = 28;

  typedef struct packed {
    logic [1:0] base;
    logic       start_of_window;
  } sample_t;

  typedef struct packed {
    logic [KEY_W-1:0] min_hash;
    logic             no_kmer;
  } result_t;

  // One accepted base as handed from the front stage to the select stage.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] mask;
    logic             start;
    logic             do_hash;
    logic             emit;
  } stage_t;

  // Invertible shift-add / xor-shift hash, every round kept to the k-mer mask.
  // The final step applies the k-mer mask once more.
  function automatic logic [KEY_W-1:0] wmh_hash(input logic [KEY_W-1:0] key,
                                                input logic [KEY_W-1:0] m);
    logic [KEY_W-1:0] x;
    x = key & m;
    x = (~x + (x << SH_A)) & m;
    x = x ^ (x >> SH_B);
    x = (x + (x << SH_C) + (x << SH_D)) & m;
    x = x ^ (x >> SH_E);
    x = (x + (x << SH_F) + (x << SH_G)) & m;
    x = x ^ (x >> SH_H);
    x = x & m;
    return x;
  endfunction

endpackage

>>> design/window_minimizer_hash.sv
// Top level of the window minimizer hash: configuration registers, length
// limits and mask, and the two pipeline stages. Depends on wmh_pkg,
// wmh_front and wmh_select.
//
//   channel   direction  handshake                     payload
//   sample    in         sample_valid / sample_stall   sample_t (base, start_of_window)
//   result    out        result_valid / result_stall   result_t (min_hash, no_kmer)
//   config    in         cfg_we                        cfg_index, cfg_data
//
// One base request is taken every cycle while sample_stall is low; a window's result
// passes through the front stage register and then the result register.
// Reset (rst, synchronous) restores k = 12, window length 20, and an idle
// block waiting for a start mark.
// A stalled result holds only the next request that ends a window; bases
// that end no window keep flowing while the result waits.
`timescale 1ns / 1ps

module window_minimizer_hash import wmh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  sample_t           sample,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result
);

  logic [KLEN_W-1:0] kmer_len;
  logic [WLEN_W-1:0] window_len;

  logic [KLEN_W-1:0] k_eff;
  logic [WLEN_W-1:0] w_eff;
  logic [4:0]        two_k;
  logic [KEY_W-1:0]  mask;

  logic              stage_valid;
  logic              stage_take;
  stage_t            stage;

  // Configuration writes take effect on the next base.
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len   <= KLEN_W'(12);
      window_len <= WLEN_W'(20);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KMER_LEN:   kmer_len   <= cfg_data[KLEN_W-1:0];
        REG_WINDOW_LEN: window_len <= cfg_data[WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero length counts as one, and lengths past the limits are clamped.
  always_comb begin
    if (kmer_len == '0) begin
      k_eff = KLEN_W'(1);
    end else if (kmer_len > KLEN_W'(KMER_MAX)) begin
      k_eff = KLEN_W'(KMER_MAX);
    end else begin
      k_eff = kmer_len;
    end
    if (window_len == '0) begin
      w_eff = WLEN_W'(1);
    end else if (32'(window_len) > 32'(WINDOW_MAX)) begin
      w_eff = WLEN_W'(WINDOW_MAX);
    end else begin
      w_eff = window_len;
    end
    two_k = {k_eff, 1'b0};
    // Mask of 2k low bits.
    mask  = {KEY_W{1'b1}} >> (5'(KEY_W) - two_k);
  end

  wmh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .k_eff        (k_eff),
    .w_eff        (w_eff),
    .mask         (mask),
    .stage_take   (stage_take),
    .stage_valid  (stage_valid),
    .stage        (stage)
  );

  wmh_select u_select (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage        (stage),
    .stage_take   (stage_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> design/wmh_front.sv
// Front stage: base shift register, window count and window state; hands a
// stage record to the select stage. Depends on wmh_pkg.
`timescale 1ns / 1ps

module wmh_front import wmh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  sample_t            sample,
  input  logic [KLEN_W-1:0]  k_eff,
  input  logic [WLEN_W-1:0]  w_eff,
  input  logic [KEY_W-1:0]   mask,
  input  logic               stage_take,
  output logic               stage_valid,
  output stage_t             stage
);

  logic [KEY_W-1:0]   kmer_shift;
  logic [COUNT_W-1:0] base_count;
  logic               window_done;

  logic               accept;
  logic               live;
  logic [KEY_W-1:0]   kmer_shift_next;
  logic [COUNT_W-1:0] base_count_next;
  logic               do_hash;
  logic               emit;

  assign sample_stall = stage_valid && !stage_take;
  assign accept       = sample_valid && !sample_stall;
  // A base without a start mark while idle is dropped.
  assign live         = sample.start_of_window || !window_done;

  always_comb begin
    kmer_shift_next = {kmer_shift[KEY_W-3:0], sample.base};
    if (sample.start_of_window) begin
      base_count_next = COUNT_W'(1);
    end else if (base_count != {COUNT_W{1'b1}}) begin
      base_count_next = base_count + COUNT_W'(1);
    end else begin
      base_count_next = base_count;
    end
    do_hash = base_count_next >= COUNT_W'(k_eff);
    emit    = base_count_next >= COUNT_W'(w_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_shift  <= '0;
      base_count  <= '0;
      window_done <= 1'b1;
      stage_valid <= 1'b0;
    end else begin
      if (accept && live) begin
        kmer_shift  <= kmer_shift_next;
        base_count  <= base_count_next;
        window_done <= emit;
        stage_valid <= 1'b1;
      end else if (stage_take) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && live) begin
      stage.key     <= kmer_shift_next & mask;
      stage.mask    <= mask;
      stage.start   <= sample.start_of_window;
      stage.do_hash <= do_hash;
      stage.emit    <= emit;
    end
  end

endmodule

>>> design/wmh_select.sv
// Select stage: hashes the k-mer, keeps the running minimum and holds the
// result register. Depends on wmh_pkg.
`timescale 1ns / 1ps

module wmh_select import wmh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    stage_valid,
  input  stage_t  stage,
  output logic    stage_take,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam logic [KEY_W:0] BEST_NONE = {(KEY_W+1){1'b1}};

  logic [KEY_W:0]   best_hash;
  logic [KEY_W:0]   best_hash_next;
  logic [KEY_W-1:0] h;
  logic [KEY_W-1:0] h_zero;

  // Only a record that emits has to wait for the result register.
  assign stage_take = stage_valid && !(result_valid && result_stall && stage.emit);

  always_comb begin
    h      = wmh_hash(stage.key, stage.mask);
    h_zero = wmh_hash('0, stage.mask);
    best_hash_next = stage.start ? BEST_NONE : best_hash;
    if (stage.do_hash && ({1'b0, h} < best_hash_next)) begin
      best_hash_next = {1'b0, h};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_hash    <= BEST_NONE;
      result_valid <= 1'b0;
    end else begin
      if (stage_take) begin
        best_hash <= best_hash_next;
      end
      if (stage_take && stage.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && stage.emit) begin
      if (best_hash_next == BEST_NONE) begin
        result.min_hash <= h_zero;
        result.no_kmer  <= 1'b1;
      end else begin
        result.min_hash <= best_hash_next[KEY_W-1:0];
        result.no_kmer  <= 1'b0;
      end
    end
  end

endmodule

>>> dv/tb.sv
// Self-checking testbench for window_minimizer_hash: streams DNA base requests in
// windows and checks each emitted minimum hash against a predictor kept here.
// Depends on wmh_pkg and the window_minimizer_hash RTL.
`timescale 1ns / 1ps

module tb;
  import wmh_pkg::*;

  // Covers the front and result registers plus margin; used before register writes and at the end.
  localparam int PIPE_SETTLE  = 4;
  localparam int BASE_GOAL    = 1600;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int REPORT_LIMIT = 10;

  // Base patterns used to fill a window.
  typedef enum int {FILL_RANDOM, FILL_ALL_A, FILL_ALL_T, FILL_CYCLE} fill_t;
  // Receiver stall behaviors; each one lasts a random stretch of cycles.
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

  // Predicts the block and checks its results in order. The state mirrors the
  // hardware: packed recent bases, a count of bases in the window, the running
  // minimum (all ones while no k-mer was hashed) and the idle flag.
  class minimizer_board;
    logic [3:0]  kmer_len;
    logic [7:0]  window_len;
    logic [29:0] kmer_shift;
    logic [7:0]  base_count;
    logic [30:0] best_hash;
    logic        window_done;
    result_t     expected_minima[$];
    int          errors;
    int          bases_taken;

    function new();
      kmer_len    = 4'd12;
      window_len  = 8'd20;
      kmer_shift  = '0;
      base_count  = '0;
      best_hash   = '1;
      window_done = 1'b1;
      errors      = 0;
      bases_taken = 0;
    endfunction

    function void set_register(logic idx, logic [CFG_W-1:0] value);
      if (idx == REG_KMER_LEN) begin
        kmer_len = value[3:0];
      end else begin
        window_len = value;
      end
    endfunction

    // Shift-add / xor-shift rounds, each addition kept to the k-mer mask.
    function logic [63:0] kmer_hash(logic [63:0] key, logic [63:0] m);
      logic [63:0] x;
      x = (~key + (key << 21)) & m;
      x = x ^ (x >> 24);
      x = (x + (x << 3) + (x << 8)) & m;
      x = x ^ (x >> 14);
      x = (x + (x << 2) + (x << 4)) & m;
      x = x ^ (x >> 28);
      x = (x + (x << 31)) & m;
      return x;
    endfunction

    function int unsigned eff_kmer();
      return (kmer_len == 0) ? 1 : kmer_len;
    endfunction

    function int unsigned eff_window();
      return (window_len == 0) ? 1 : window_len;
    endfunction

    function int pending();
      return expected_minima.size();
    endfunction

    function void take_base(sample_t s);
      int unsigned k;
      int unsigned w;
      logic [63:0] m;
      logic [63:0] h;
      result_t     r;
      k = eff_kmer();
      w = eff_window();
      m = (64'd1 << (2 * k)) - 64'd1;
      if (s.start_of_window) begin
        base_count  = '0;
        best_hash   = '1;
        window_done = 1'b0;
      end else if (window_done) begin
        return;
      end
      bases_taken++;
      kmer_shift = {kmer_shift[27:0], s.base};
      if (base_count != 8'hFF) base_count++;
      // Stale bases from before the start never reach a hash: the count gates it.
      if (base_count >= k) begin
        h = kmer_hash({34'd0, kmer_shift} & m, m);
        if (h[30:0] < best_hash) best_hash = h[30:0];
      end
      if (base_count >= w) begin
        window_done = 1'b1;
        if (best_hash == '1) begin
          h = kmer_hash(64'd0, m);
          r.min_hash = h[29:0];
          r.no_kmer  = 1'b1;
        end else begin
          r.min_hash = best_hash[29:0];
          r.no_kmer  = 1'b0;
        end
        expected_minima = {expected_minima, r};
      end
    endfunction

    function void check_minimum(result_t got);
      result_t want;
      if (expected_minima.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result min_hash=%h no_kmer=%b",
                   $realtime, got.min_hash, got.no_kmer);
        return;
      end
      want = expected_minima.pop_front();
      if (got.min_hash !== want.min_hash || got.no_kmer !== want.no_kmer) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: mismatch min_hash exp %h got %h, no_kmer exp %b got %b",
                   $realtime, want.min_hash, got.min_hash, want.no_kmer, got.no_kmer);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_KMER_LEN;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             sample_valid = 1'b0;
  logic             sample_stall;
  sample_t          base_req = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          minimum;

  minimizer_board sb;

  // Sender pacing: bursts of random length separated by random gaps, unless
  // the current phase runs gapless.
  bit gapless = 1'b0;
  int burst_left = 0;

  // Receiver state. The long hold-off is requested once by the stimulus and
  // then counted out here, independent of the sender.
  bit       hold_go = 1'b0;
  bit       hold_used = 1'b0;
  int       hold_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;
  int       cycles = 0;

  window_minimizer_hash uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (base_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (minimum)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall pattern changes every stretch, with free-running stretches
  // mixed in. Outputs are read at the edge, so they are the settled pre-edge values.
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      case (rx_mode)
        RX_FREE:  result_stall <= 1'b0;
        RX_LIGHT: result_stall <= ($urandom_range(0, 9) < 3);
        RX_HEAVY: result_stall <= ($urandom_range(0, 9) < 8);
        default:  result_stall <= ((rx_left % 6) < 3);
      endcase
    end
  end

  // Result monitor: every accepted result is checked against the oldest
  // expected minimum.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_minimum(minimum);
  end

  // Offers one base request and returns at the edge where it is accepted.
  // The predictor is updated right here, so its queue of expected minima is
  // never behind the request stream when the main flow looks at it.
  task automatic send_base(input logic [1:0] b, input logic sow);
    sample_t s;
    s.base = b;
    s.start_of_window = sow;
    if (!gapless) begin
      if (burst_left == 0) begin
        sample_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    base_req     <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    sb.take_base(s);
  endtask

  // Brings the block to rest: no request offered, every expected minimum in,
  // and time for a base that ends no window to leave the pipeline.
  task automatic settle();
    sample_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Writes both length registers on back-to-back edges. The unused upper bits
  // of the k-mer length write carry noise, which the register must drop.
  task automatic program_lengths(input logic [3:0] k, input logic [7:0] w);
    logic [CFG_W-1:0] kdata;
    kdata = {4'($urandom_range(0, 15)), k};
    cfg_we    <= 1'b1;
    cfg_index <= REG_KMER_LEN;
    cfg_data  <= kdata;
    @(posedge clk);
    sb.set_register(REG_KMER_LEN, kdata);
    cfg_index <= REG_WINDOW_LEN;
    cfg_data  <= w;
    @(posedge clk);
    sb.set_register(REG_WINDOW_LEN, w);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [1:0] pick_base(fill_t style, int pos);
    case (style)
      FILL_ALL_A: return 2'd0;
      FILL_ALL_T: return 2'd3;
      FILL_CYCLE: return 2'(pos % 4);
      default:    return 2'($urandom_range(0, 3));
    endcase
  endfunction

  // One window of n bases, the first carrying the start mark.
  task automatic send_window(input int n);
    fill_t style;
    style = fill_t'($urandom_range(0, 9) < 7 ? FILL_RANDOM : $urandom_range(1, 3));
    for (int i = 0; i < n; i++) send_base(pick_base(style, i), i == 0);
  endtask

  function automatic logic [7:0] pick_window_len();
    case ($urandom_range(0, 19))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      3, 4, 5: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic logic [3:0] pick_kmer_len();
    case ($urandom_range(0, 9))
      0:       return 4'd0;
      1:       return 4'd15;
      2:       return 4'd1;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  initial begin
    int unsigned w_eff;
    int          windows;
    int          kind;
    bit          pressure_done;
    logic [3:0]  k;
    logic [7:0]  w;

    sb = new();
    pressure_done = 1'b0;
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Bases arriving before any start mark must be ignored.
    send_base(2'd3, 1'b0);
    send_base(2'd0, 1'b0);
    settle();

    // Zero lengths act as one: every start base is a whole window and a
    // single-base k-mer, so each base code yields its own minimum.
    program_lengths(4'd0, 8'd0);
    for (int b = 0; b < 4; b++) send_base(2'(b), 1'b1);
    settle();

    // Window shorter than k: the result is the hash of key zero, flagged.
    program_lengths(4'd15, 8'd2);
    send_base(2'd3, 1'b1);
    send_base(2'd3, 1'b0);
    settle();

    // A start mark in the middle of a window drops the unfinished one; old
    // bases left in the shift register must not leak into the new k-mers.
    // The trailing base arrives after the window closed and is ignored.
    program_lengths(4'd2, 8'd3);
    send_base(2'd1, 1'b1);
    send_base(2'd2, 1'b0);
    send_base(2'd0, 1'b1);
    send_base(2'd3, 1'b0);
    send_base(2'd3, 1'b0);
    send_base(2'd2, 1'b0);
    settle();

    // All-T window: the largest key value for this k.
    program_lengths(4'd3, 8'd4);
    for (int i = 0; i < 4; i++) send_base(2'd3, i == 0);

    // Random part: phases of one register setting each, mostly well-formed
    // windows with random content, plus cut-off windows, stray bases and
    // windows left open across a register change.
    while (sb.bases_taken < BASE_GOAL) begin
      settle();

      // Once, fill the block up: every base ends a window while the receiver
      // holds off for a long stretch and the sender keeps offering.
      if (!pressure_done && sb.bases_taken >= BASE_GOAL / 2) begin
        pressure_done = 1'b1;
        program_lengths(pick_kmer_len(), 8'd1);
        hold_go <= 1'b1;
        gapless = 1'b1;
        for (int i = 0; i < 60; i++) send_base(2'($urandom_range(0, 3)), 1'b1);
        settle();
      end

      k = pick_kmer_len();
      w = pick_window_len();
      program_lengths(k, w);
      w_eff   = (w == 0) ? 1 : w;
      gapless = ($urandom_range(0, 3) == 0);
      windows = (w_eff > 64) ? 1 : $urandom_range(1, 10);

      repeat (windows) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          send_window(w_eff);
        end else if (kind < 9) begin
          send_window($urandom_range(1, w_eff));
        end else begin
          // Bases without a start mark: ignored if the window is closed,
          // otherwise they continue an open one.
          repeat ($urandom_range(1, 4)) send_base(2'($urandom_range(0, 3)), 1'b0);
        end
      end

      // Sometimes leave a window open so the next setting applies mid-window.
      if (w_eff > 1 && $urandom_range(0, 4) == 0) send_window($urandom_range(1, w_eff - 1));
    end

    settle();
    repeat (PIPE_SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
